/* sv/position_deque_with_shift_macros.svh */
// ----------------------------------------------------------------------------
// Position deque assertion macros
// Shared concurrent assertion forms for the position deque checker.
// ----------------------------------------------------------------------------
`ifndef POSITION_DEQUE_WITH_SHIFT_MACROS_SVH
`define POSITION_DEQUE_WITH_SHIFT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdq assertion failed");

// Next-cycle implication that is checked during reset as well.
`define PDQ_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pdq assertion failed");

`endif

/* sv/pdq_pkg.sv */
// ----------------------------------------------------------------------------
// Position deque package
// Sizes, entry type, request codes and cell control shared by the design.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int DEPTH      = 64;
  localparam int COORD_BITS = 8;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } entry_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_CLEAR      = 3'd4,
    FN_SHIFT      = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    CM_KEEP       = 2'd0,
    CM_FROM_FRONT = 2'd1,
    CM_FROM_BACK  = 2'd2,
    CM_LOAD       = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     load_data;
  } cell_ctrl_t;

endpackage

/* sv/pdq_cell.sv */
// ----------------------------------------------------------------------------
// Position deque cell
// One storage slot of the deque chain. It keeps its entry, takes the entry of
// its front or back neighbor, or loads the pushed entry when it is the tail.
// ----------------------------------------------------------------------------
module pdq_cell (
  input  logic                clk,
  input  pdq_pkg::cell_ctrl_t ctrl,
  input  logic                tail_sel,
  input  pdq_pkg::entry_t     front_data,
  input  pdq_pkg::entry_t     back_data,
  output pdq_pkg::entry_t     data_q
);
  import pdq_pkg::*;

  entry_t data_r;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CM_KEEP: begin
      end
      CM_FROM_FRONT: begin
        data_r <= front_data;
      end
      CM_FROM_BACK: begin
        data_r <= back_data;
      end
      CM_LOAD: begin
        if (tail_sel) begin
          data_r <= ctrl.load_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign data_q = data_r;

endmodule

/* sv/position_deque_with_shift.sv */
// ----------------------------------------------------------------------------
// Position deque with shift
// Bounded double-ended queue of (column, row) positions built as a chain of
// storage cells, with the front entry always in cell zero.
//
//   Channel  Direction  Handshake             Beat contents
//   in_      input      in_valid / in_ready   in_func, in_col, in_row
//   out_     output     out_valid / out_ready out_col, out_row,
//                                             out_entry_count, out_overflow
//
// Every request is applied to the cell chain in the cycle it is accepted and
// its result beat appears in the output register on the next cycle.
// One request per cycle is taken while the result register drains each cycle.
// A stalled output register holds in_ready low until its beat is taken.
// Reset empties the deque; cell contents are not cleared.
// ----------------------------------------------------------------------------
module position_deque_with_shift (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pdq_pkg::FUNC_W-1:0]     in_func,
  input  logic [pdq_pkg::COORD_BITS-1:0] in_col,
  input  logic [pdq_pkg::COORD_BITS-1:0] in_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pdq_pkg::COORD_BITS-1:0] out_col,
  output logic [pdq_pkg::COORD_BITS-1:0] out_row,
  output logic [pdq_pkg::CNT_W-1:0]      out_entry_count,
  output logic                           out_overflow
);
  import pdq_pkg::*;

  entry_t               cell_q [DEPTH];
  logic [DEPTH-1:0]     tail_hit;
  entry_t               in_entry;
  entry_t               head_in;
  entry_t               back_entry;
  cell_ctrl_t           ctrl;
  logic                 fire_in;
  logic                 full;
  logic                 empty;
  logic [CNT_W-1:0]     cnt_dec;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     tail_idx;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  entry_t               res_r;
  entry_t               res_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;

  assign in_entry = '{col: in_col, row: in_row};
  assign fire_in  = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign cnt_dec  = count_r - CNT_W'(1);
  assign last_idx = cnt_dec[IDX_W-1:0];
  assign tail_idx = count_r[IDX_W-1:0];

  always_comb begin
    back_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_idx == IDX_W'(i)) begin
        back_entry = back_entry | cell_q[i];
      end
    end
  end

  always_comb begin
    ctrl           = '{mode: CM_KEEP, load_data: in_entry};
    head_in        = in_entry;
    count_nxt      = count_r;
    res_nxt        = '0;
    ovf_nxt        = 1'b0;
    if (fire_in) begin
      case (func_t'(in_func))
        FN_PUSH_FRONT: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctrl.mode = CM_FROM_FRONT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctrl.mode = CM_LOAD;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_POP_FRONT: begin
          if (!empty) begin
            res_nxt   = cell_q[0];
            ctrl.mode = CM_FROM_BACK;
            count_nxt = cnt_dec;
          end
        end
        FN_POP_BACK: begin
          if (!empty) begin
            res_nxt   = back_entry;
            count_nxt = cnt_dec;
          end
        end
        FN_CLEAR: begin
          count_nxt = '0;
        end
        FN_SHIFT: begin
          if (!empty) begin
            ctrl.mode = CM_FROM_FRONT;
            head_in   = cell_q[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t front_src;
    entry_t back_src;

    assign tail_hit[g] = (tail_idx == IDX_W'(g));
    if (g == 0) begin : g_head
      assign front_src = head_in;
    end else begin : g_body
      assign front_src = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign back_src = cell_q[g];
    end else begin : g_inner
      assign back_src = cell_q[g+1];
    end

    pdq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .tail_sel   (tail_hit[g]),
      .front_data (front_src),
      .back_data  (back_src),
      .data_q     (cell_q[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_in) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_col   = res_r.col;
  assign out_row   = res_r.row;
  // The count register already holds the value after the beat in the output stage.
  assign out_entry_count = count_r;
  assign out_overflow    = ovf_r;

endmodule

/* sv/pdq_checker.sv */
// ----------------------------------------------------------------------------
// Position deque checker
// Port-level assertions for the position deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "position_deque_with_shift_macros.svh"

module pdq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [pdq_pkg::FUNC_W-1:0]     in_func,
  input logic [pdq_pkg::COORD_BITS-1:0] in_col,
  input logic [pdq_pkg::COORD_BITS-1:0] in_row,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pdq_pkg::COORD_BITS-1:0] out_col,
  input logic [pdq_pkg::COORD_BITS-1:0] out_row,
  input logic [pdq_pkg::CNT_W-1:0]      out_entry_count,
  input logic                           out_overflow
);
  import pdq_pkg::*;

  `PDQ_ASSERT_RST(a_reset_idle, !rst_n, !out_valid)
  `PDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_col) && $stable(out_row) && $stable(out_overflow))
  `PDQ_ASSERT_NEXT(a_clear_empty, in_valid && in_ready && (in_func == FN_CLEAR),
    out_valid && (out_entry_count == '0) && !out_overflow)
  `PDQ_ASSERT_NOW(a_ovf_full, out_valid && out_overflow,
    (out_entry_count == CNT_W'(DEPTH)) && (out_col == '0) && (out_row == '0))
  `PDQ_ASSERT_NOW(a_count_range, out_valid, out_entry_count <= CNT_W'(DEPTH))

endmodule

bind position_deque_with_shift pdq_checker u_pdq_checker (.*);
